FILE: rtl/lzari_pkg.sv
// Shared constants, entry type and reset helper for the LZARI token encoder.
// Depends on nothing; every other file in rtl/ but lzari_ram refers to it by scoped names.
package lzari_pkg;

	localparam int MAX_MATCH    = 60;
	localparam int WINDOW_SIZE  = 4096;
	localparam int SYMBOL_COUNT = 314;

	localparam int RANKS   = SYMBOL_COUNT + 1;
	localparam int RANK_W  = $clog2(RANKS);
	localparam int CHR_W   = $clog2(SYMBOL_COUNT);
	localparam int FREQ_W  = 16;
	localparam int IVL_W   = 18;
	localparam int DIST_W  = $clog2(WINDOW_SIZE + 1);
	localparam int DVD_W   = IVL_W + FREQ_W;
	localparam int FOL_W   = 16;

	localparam logic [IVL_W-1:0] QTR1 = 18'h08000;
	localparam logic [IVL_W-1:0] HALF = 18'h10000;
	localparam logic [IVL_W-1:0] QTR3 = 18'h18000;
	localparam logic [IVL_W-1:0] FULL = 18'h20000;
	localparam logic [FREQ_W-1:0] CUM_LIMIT = 16'h7fff;

	localparam int MATCH_BASE   = 253;
	localparam int FLUSH_ZEROS  = 17;
	localparam int RENORM_STEPS = 18;

	localparam int POS_NUM = 10000;
	localparam int POS_OFF = 200;
	localparam int POS_Q0  = POS_NUM / (WINDOW_SIZE + POS_OFF);
	localparam int POS_P0  = POS_Q0 * (WINDOW_SIZE + POS_OFF);

	localparam logic [1:0] MODE_LIT    = 2'd0;
	localparam logic [1:0] MODE_MATCH  = 2'd1;
	localparam logic [1:0] MODE_FINISH = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [CHR_W-1:0]  chr;
		logic [FREQ_W-1:0] freq;
		logic [FREQ_W-1:0] cum;
	} entry_t;

	function automatic entry_t entry_init(input logic [RANK_W-1:0] rank);
		entry_t e;
		e.chr  = (rank == '0) ? '0 : CHR_W'(rank - 1'b1);
		e.freq = (rank == '0) ? '0 : FREQ_W'(1);
		e.cum  = FREQ_W'(SYMBOL_COUNT) - FREQ_W'(rank);
		return e;
	endfunction

endpackage

FILE: rtl/lzari_if.sv
// Token and result channel interfaces with valid/ready handshake.
// Depends on lzari_pkg for field widths.
interface lzari_tok_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  mode;
	logic [7:0]                  literal_byte;
	logic [5:0]                  match_length;
	logic [lzari_pkg::DIST_W-1:0] match_distance;
	modport source (output valid, mode, literal_byte, match_length, match_distance,
		input ready);
	modport sink (input valid, mode, literal_byte, match_length, match_distance,
		output ready);
endinterface

interface lzari_res_if;
	logic                       valid;
	logic                       ready;
	logic                       first_bit;
	logic [lzari_pkg::FOL_W-1:0] follow_count;
	logic                       follow_overflow;
	logic                       last;
	modport source (output valid, first_bit, follow_count, follow_overflow, last,
		input ready);
	modport sink (input valid, first_bit, follow_count, follow_overflow, last,
		output ready);
endinterface

FILE: rtl/lzari_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lzari_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4097
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/lzari_cell.sv
// One rank of the circulating frequency model: char, frequency, cumulative.
// Depends on lzari_pkg for entry_t and the per-rank reset image.
module lzari_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lzari_pkg::RANK_W-1:0] rank,
	input  logic                         shift,
	input  logic                         init,
	input  lzari_pkg::entry_t            d,
	output lzari_pkg::entry_t            q
);
	lzari_pkg::entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= lzari_pkg::entry_init(rank);
		end else if (init) begin
			entry_q <= lzari_pkg::entry_init(rank);
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;
endmodule

FILE: rtl/lzari_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lzari_pkg for operand widths.
module lzari_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lzari_pkg::DVD_W-1:0]  dividend,
	input  logic [lzari_pkg::FREQ_W-1:0] divisor,
	output logic                         busy,
	output logic [lzari_pkg::DVD_W-1:0]  quotient
);
	localparam int CNT_W = $clog2(lzari_pkg::DVD_W + 1);

	logic [lzari_pkg::DVD_W-1:0]  quo_q;
	logic [lzari_pkg::FREQ_W-1:0] rem_q;
	logic [lzari_pkg::FREQ_W-1:0] dsr_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic [lzari_pkg::FREQ_W:0]   trial;
	logic                         fits;

	assign trial = {rem_q, quo_q[lzari_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(lzari_pkg::DVD_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[lzari_pkg::DVD_W-2:0], fits};
			rem_q <= fits ? lzari_pkg::FREQ_W'(trial - {1'b0, dsr_q})
				: trial[lzari_pkg::FREQ_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

FILE: rtl/lzari_arith_token_encoder_unit.sv
// LZARI arithmetic token encoder: adaptive 314-symbol model plus distance table.
// Depends on lzari_pkg, lzari_if, lzari_cell, lzari_div and lzari_ram.
//
// After reset the block builds the distance table of WINDOW_SIZE+1 entries in RAM
// and accepts no request until done. The model ranks sit in a ring of 315 cells
// that rotates one rank per cycle while a pass over the ring runs. A literal takes
// one turn to locate its rank, a multiply and a divide for each bound of the new
// interval, up to RENORM_STEPS renormalization steps, and one turn to update, plus
// two more turns when the model is halved. A match adds a table read and a second
// coded interval. Finish emits 18 results and reloads the reset state. Results
// stall the coder only when the output is full.
module lzari_arith_token_encoder_unit (
	input logic        clk,
	input logic        arst_n,
	lzari_tok_if.sink  tok,
	lzari_res_if.source res
);
	localparam int RANK_W = lzari_pkg::RANK_W;
	localparam int CHR_W  = lzari_pkg::CHR_W;
	localparam int FW     = lzari_pkg::FREQ_W;
	localparam int IW     = lzari_pkg::IVL_W;
	localparam int DW     = lzari_pkg::DIST_W;
	localparam int STEP_W = $clog2(lzari_pkg::RENORM_STEPS + 1);
	localparam int FIN_W  = $clog2(lzari_pkg::FLUSH_ZEROS + 1);
	localparam int PW     = FW + 1;

	typedef enum logic [11:0] {
		ST_FILL    = 12'b000000000001,
		ST_IDLE    = 12'b000000000010,
		ST_FIND    = 12'b000000000100,
		ST_MUL     = 12'b000000001000,
		ST_DIV     = 12'b000000010000,
		ST_RENORM  = 12'b000000100000,
		ST_SUM     = 12'b000001000000,
		ST_REWRITE = 12'b000010000000,
		ST_UPDATE  = 12'b000100000000,
		ST_POSRD   = 12'b001000000000,
		ST_FINISH  = 12'b010000000000,
		ST_DONE    = 12'b100000000000
	} state_t;

	state_t state_q;

	lzari_pkg::entry_t cell_q [lzari_pkg::RANKS];
	lzari_pkg::entry_t head;
	lzari_pkg::entry_t tail_d;
	logic              ring_shift;
	logic              ring_init;

	logic [RANK_W-1:0] k_q, r_q, i_q, rs_q;
	logic [CHR_W-1:0]  c_q, a_q, rsch_q;
	logic [FW-1:0]     prevf_q, prevcum_q, cprev_q, cthis_q, total_q, ctotal_q;
	logic [FW-1:0]     sumt_q, pre_q;
	logic [DW-1:0]     dist_q;
	logic              is_match_q, coding_dist_q, second_q, div_started_q;
	logic [IW-1:0]     lo_q, hi_q, hinew_q;
	logic [lzari_pkg::DVD_W-1:0] prod_q;
	logic [STEP_W-1:0] step_q;
	logic [FIN_W-1:0]  fin_q;
	logic [lzari_pkg::FOL_W-1:0] fol_q;
	logic              sat_q;

	logic [DW-1:0]     fill_k_q;
	logic [FW-1:0]     fill_acc_q, pq_q, pp_q, pos_total_q;

	logic              pend_valid_q, pbit_q, povf_q;
	logic [lzari_pkg::FOL_W-1:0] pcnt_q;
	logic              out_valid_q, obit_q, oovf_q, olast_q;
	logic [lzari_pkg::FOL_W-1:0] ocnt_q;

	logic [FW-1:0]     f_half, f_cur, rs_newcum;
	logic              run_new;
	logic [RANK_W-1:0] rs_eff;
	logic [CHR_W-1:0]  rsch_eff;
	logic              ren_c1, ren_c2, ren_c3;
	logic [lzari_pkg::FOL_W-1:0] fol_inc;
	logic              sat_inc;
	logic              emit_req, emit_bit, emit_ovf, stall, out_free, out_load;
	logic [lzari_pkg::FOL_W-1:0] emit_cnt;
	logic              done_flush;
	logic              pass_end;
	logic [IW-1:0]     rng, div_sum;
	logic [FW-1:0]     mul_c;
	logic              div_start, div_busy;
	logic [lzari_pkg::DVD_W-1:0] div_quo;
	logic              ram_we;
	logic [DW-1:0]     ram_raddr;
	logic [FW-1:0]     ram_rdata;
	logic [PW-1:0]     pp_dec, m_next;
	logic [7:0]        len_c;
	logic [9:0]        chr_m;
	logic [DW-1:0]     dist_c;
	state_t            after_code;

	genvar p;
	generate
		for (p = 0; p < lzari_pkg::RANKS; p++) begin : g_ring
			if (p < lzari_pkg::RANKS - 1) begin : g_mid
				lzari_cell u_cell (
					.clk(clk), .arst_n(arst_n), .rank(RANK_W'(p)), .shift(ring_shift),
					.init(ring_init), .d(cell_q[p+1]), .q(cell_q[p])
				);
			end else begin : g_tail
				lzari_cell u_cell (
					.clk(clk), .arst_n(arst_n), .rank(RANK_W'(p)), .shift(ring_shift),
					.init(ring_init), .d(tail_d), .q(cell_q[p])
				);
			end
		end
	endgenerate

	lzari_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(prod_q),
		.divisor(total_q), .busy(div_busy), .quotient(div_quo)
	);

	lzari_ram #(.WIDTH(FW), .DEPTH(lzari_pkg::WINDOW_SIZE + 1)) u_pos (
		.clk(clk), .we(ram_we), .waddr(fill_k_q), .wdata(fill_acc_q),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign head       = cell_q[0];
	assign ring_shift = (state_q == ST_FIND) || (state_q == ST_SUM)
		|| (state_q == ST_REWRITE) || (state_q == ST_UPDATE);
	assign ring_init  = (state_q == ST_FINISH) && !stall
		&& (fin_q == FIN_W'(lzari_pkg::FLUSH_ZEROS));
	assign pass_end   = k_q == RANK_W'(lzari_pkg::RANKS - 1);

	assign f_half    = FW'((PW'(head.freq) + PW'(1)) >> 1);
	assign f_cur     = (state_q == ST_REWRITE) ? f_half : head.freq;
	assign run_new   = (k_q == RANK_W'(1)) || (f_cur != prevf_q);
	assign rs_eff    = run_new ? k_q : rs_q;
	assign rsch_eff  = run_new ? head.chr : rsch_q;
	assign rs_newcum = sumt_q - (pre_q + f_half);

	always_comb begin
		tail_d = head;
		case (state_q)
			ST_REWRITE: begin
				tail_d.freq = f_half;
				tail_d.cum  = rs_newcum;
			end
			ST_UPDATE: begin
				if (k_q < i_q) begin
					tail_d.cum = head.cum + 1'b1;
				end else if (k_q == i_q) begin
					tail_d.chr  = c_q;
					tail_d.freq = head.freq + 1'b1;
				end else if (k_q == r_q) begin
					tail_d.chr = a_q;
				end
			end
			default: tail_d = head;
		endcase
	end

	assign ren_c1  = hi_q <= lzari_pkg::HALF;
	assign ren_c2  = lo_q >= lzari_pkg::HALF;
	assign ren_c3  = (lo_q >= lzari_pkg::QTR1) && (hi_q <= lzari_pkg::QTR3);
	assign fol_inc = (fol_q == '1) ? fol_q : fol_q + 1'b1;
	assign sat_inc = sat_q || (fol_q == '1);
	assign out_free = !out_valid_q || res.ready;

	always_comb begin
		emit_req = 1'b0;
		emit_bit = 1'b0;
		emit_cnt = fol_q;
		emit_ovf = sat_q;
		case (state_q)
			ST_RENORM: begin
				if (step_q != STEP_W'(lzari_pkg::RENORM_STEPS) && (ren_c1 || ren_c2)) begin
					emit_req = 1'b1;
					emit_bit = !ren_c1;
				end
			end
			ST_FINISH: begin
				emit_req = 1'b1;
				if (fin_q == '0) begin
					emit_bit = lo_q >= lzari_pkg::QTR1;
					emit_cnt = fol_inc;
					emit_ovf = sat_inc;
				end else begin
					emit_cnt = '0;
					emit_ovf = 1'b0;
				end
			end
			default: emit_req = 1'b0;
		endcase
	end

	assign stall      = emit_req && pend_valid_q && !out_free;
	assign done_flush = (state_q == ST_DONE) && pend_valid_q && out_free;
	assign out_load   = (emit_req && !stall && pend_valid_q) || done_flush;

	assign rng     = hi_q - lo_q;
	assign mul_c   = second_q ? cthis_q : cprev_q;
	assign div_sum = lo_q + div_quo[IW-1:0];
	assign div_start = (state_q == ST_DIV) && !div_started_q;

	assign ram_we    = state_q == ST_FILL;
	assign ram_raddr = (step_q == '0) ? dist_q - 1'b1 : dist_q;
	assign pp_dec    = PW'(pp_q) - PW'(pq_q);
	assign m_next    = PW'(fill_k_q) - PW'(1) + PW'(lzari_pkg::POS_OFF);

	assign after_code = coding_dist_q ? ST_DONE
		: (ctotal_q >= lzari_pkg::CUM_LIMIT) ? ST_SUM : ST_UPDATE;

	always_comb begin
		len_c = 8'(tok.match_length);
		if (len_c < 8'd3) begin
			len_c = 8'd3;
		end else if (len_c > 8'(lzari_pkg::MAX_MATCH)) begin
			len_c = 8'(lzari_pkg::MAX_MATCH);
		end
		chr_m = 10'(lzari_pkg::MATCH_BASE) + 10'(len_c);
		if (chr_m > 10'(lzari_pkg::SYMBOL_COUNT - 1)) begin
			chr_m = 10'(lzari_pkg::SYMBOL_COUNT - 1);
		end
		dist_c = tok.match_distance;
		if (dist_c == '0) begin
			dist_c = DW'(1);
		end else if (dist_c > DW'(lzari_pkg::WINDOW_SIZE)) begin
			dist_c = DW'(lzari_pkg::WINDOW_SIZE);
		end
	end

	assign tok.ready = state_q == ST_IDLE;

	// Sequencer and coder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_FILL;
			k_q           <= '0;
			lo_q          <= '0;
			hi_q          <= lzari_pkg::FULL;
			fol_q         <= '0;
			sat_q         <= 1'b0;
			fill_k_q      <= DW'(lzari_pkg::WINDOW_SIZE);
			fill_acc_q    <= '0;
			pq_q          <= FW'(lzari_pkg::POS_Q0);
			pp_q          <= FW'(lzari_pkg::POS_P0);
			second_q      <= 1'b0;
			div_started_q <= 1'b0;
			coding_dist_q <= 1'b0;
			is_match_q    <= 1'b0;
			step_q        <= '0;
			fin_q         <= '0;
			pend_valid_q  <= 1'b0;
		end else begin
			if (emit_req && !stall) begin
				pend_valid_q <= 1'b1;
				pbit_q       <= emit_bit;
				pcnt_q       <= emit_cnt;
				povf_q       <= emit_ovf;
			end
			case (state_q)
				ST_FILL: begin
					if (fill_k_q == '0) begin
						pos_total_q <= fill_acc_q;
						state_q     <= ST_IDLE;
					end else begin
						fill_acc_q <= fill_acc_q + pq_q;
						fill_k_q   <= fill_k_q - 1'b1;
						if (pp_dec + m_next <= PW'(lzari_pkg::POS_NUM)) begin
							pq_q <= pq_q + 1'b1;
							pp_q <= FW'(pp_dec + m_next);
						end else begin
							pp_q <= FW'(pp_dec);
						end
					end
				end
				ST_IDLE: begin
					if (tok.valid) begin
						coding_dist_q <= 1'b0;
						dist_q        <= dist_c;
						case (tok.mode)
							lzari_pkg::MODE_LIT: begin
								c_q        <= CHR_W'(tok.literal_byte);
								is_match_q <= 1'b0;
								state_q    <= ST_FIND;
							end
							lzari_pkg::MODE_MATCH: begin
								c_q        <= CHR_W'(chr_m);
								is_match_q <= 1'b1;
								state_q    <= ST_FIND;
							end
							lzari_pkg::MODE_FINISH: begin
								fin_q   <= '0;
								state_q <= ST_FINISH;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FIND: begin
					prevcum_q <= head.cum;
					prevf_q   <= f_cur;
					if (k_q == '0) begin
						ctotal_q <= head.cum;
						total_q  <= head.cum;
					end else begin
						rs_q   <= rs_eff;
						rsch_q <= rsch_eff;
						if (head.chr == c_q) begin
							r_q     <= k_q;
							cprev_q <= prevcum_q;
							cthis_q <= head.cum;
							i_q     <= rs_eff;
							a_q     <= rsch_eff;
						end
					end
					k_q <= pass_end ? '0 : k_q + 1'b1;
					if (pass_end) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (total_q == '0) begin
						state_q <= after_code;
					end else begin
						prod_q        <= lzari_pkg::DVD_W'(rng) * lzari_pkg::DVD_W'(mul_c);
						div_started_q <= 1'b0;
						state_q       <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_started_q) begin
						div_started_q <= 1'b1;
					end else if (!div_busy) begin
						if (!second_q) begin
							hinew_q  <= div_sum;
							second_q <= 1'b1;
							state_q  <= ST_MUL;
						end else begin
							lo_q     <= div_sum;
							hi_q     <= hinew_q;
							second_q <= 1'b0;
							step_q   <= '0;
							state_q  <= ST_RENORM;
						end
					end
				end
				ST_RENORM: begin
					if (step_q == STEP_W'(lzari_pkg::RENORM_STEPS)) begin
						state_q <= after_code;
					end else if (ren_c1) begin
						if (!stall) begin
							fol_q  <= '0;
							sat_q  <= 1'b0;
							lo_q   <= lo_q << 1;
							hi_q   <= hi_q << 1;
							step_q <= step_q + 1'b1;
						end
					end else if (ren_c2) begin
						if (!stall) begin
							fol_q  <= '0;
							sat_q  <= 1'b0;
							lo_q   <= (lo_q - lzari_pkg::HALF) << 1;
							hi_q   <= (hi_q - lzari_pkg::HALF) << 1;
							step_q <= step_q + 1'b1;
						end
					end else if (ren_c3) begin
						fol_q  <= fol_inc;
						sat_q  <= sat_inc;
						lo_q   <= (lo_q - lzari_pkg::QTR1) << 1;
						hi_q   <= (hi_q - lzari_pkg::QTR1) << 1;
						step_q <= step_q + 1'b1;
					end else begin
						state_q <= after_code;
					end
				end
				ST_SUM: begin
					sumt_q <= (k_q == '0) ? f_half : sumt_q + f_half;
					pre_q  <= '0;
					k_q    <= pass_end ? '0 : k_q + 1'b1;
					if (pass_end) begin
						state_q <= ST_REWRITE;
					end
				end
				ST_REWRITE: begin
					pre_q   <= pre_q + f_half;
					prevf_q <= f_cur;
					if (k_q != '0) begin
						rs_q   <= rs_eff;
						rsch_q <= rsch_eff;
						if (k_q == r_q) begin
							i_q <= rs_eff;
							a_q <= rsch_eff;
						end
					end
					k_q <= pass_end ? '0 : k_q + 1'b1;
					if (pass_end) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					k_q <= pass_end ? '0 : k_q + 1'b1;
					if (pass_end) begin
						step_q  <= '0;
						state_q <= is_match_q ? ST_POSRD : ST_DONE;
					end
				end
				ST_POSRD: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(1)) begin
						cprev_q <= ram_rdata;
					end else if (step_q == STEP_W'(2)) begin
						cthis_q       <= ram_rdata;
						total_q       <= pos_total_q;
						coding_dist_q <= 1'b1;
						state_q       <= ST_MUL;
					end
				end
				ST_FINISH: begin
					if (!stall) begin
						fol_q <= '0;
						sat_q <= 1'b0;
						fin_q <= fin_q + 1'b1;
						if (fin_q == FIN_W'(lzari_pkg::FLUSH_ZEROS)) begin
							lo_q    <= '0;
							hi_q    <= lzari_pkg::FULL;
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
			obit_q      <= pbit_q;
			ocnt_q      <= pcnt_q;
			oovf_q      <= povf_q;
			olast_q     <= done_flush;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.first_bit       = obit_q;
	assign res.follow_count    = ocnt_q;
	assign res.follow_overflow = oovf_q;
	assign res.last            = olast_q;

`ifndef SYNTHESIS
	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (k_q == '0))
		else $error("ring not aligned at idle");
	a_no_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held result left at idle");
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_busy)
		else $error("divider busy at idle");
	a_init_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		ring_init |=> (state_q == ST_DONE))
		else $error("model reload outside flush end");
`endif
endmodule

FILE: sim/lzari_checker.sv
// Checker for the LZARI token encoder: watches both channels, predicts results.
// Depends on lzari_pkg and the lzari_tok_if / lzari_res_if interfaces.
module lzari_checker (
	input  logic  clk,
	input  logic  arst_n,
	lzari_tok_if  tok,
	lzari_res_if  res,
	output int    fails,
	output int    outstanding,
	output int    checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FOL_W        = lzari_pkg::FOL_W;
	localparam int SYMBOL_COUNT = lzari_pkg::SYMBOL_COUNT;
	localparam int RANKS        = lzari_pkg::RANKS;
	localparam int WINDOW_SIZE  = lzari_pkg::WINDOW_SIZE;
	localparam int DIST_W       = lzari_pkg::DIST_W;
	localparam int MAX_MATCH    = lzari_pkg::MAX_MATCH;
	localparam int MATCH_BASE   = lzari_pkg::MATCH_BASE;
	localparam int FLUSH_ZEROS  = lzari_pkg::FLUSH_ZEROS;
	localparam int RENORM_STEPS = lzari_pkg::RENORM_STEPS;
	localparam int POS_NUM      = lzari_pkg::POS_NUM;
	localparam int POS_OFF      = lzari_pkg::POS_OFF;
	localparam int unsigned QTR1      = lzari_pkg::QTR1;
	localparam int unsigned HALF      = lzari_pkg::HALF;
	localparam int unsigned QTR3      = lzari_pkg::QTR3;
	localparam int unsigned FULL      = lzari_pkg::FULL;
	localparam int unsigned CUM_LIMIT = lzari_pkg::CUM_LIMIT;
	localparam logic [1:0] MODE_LIT    = lzari_pkg::MODE_LIT;
	localparam logic [1:0] MODE_MATCH  = lzari_pkg::MODE_MATCH;
	localparam logic [1:0] MODE_FINISH = lzari_pkg::MODE_FINISH;

	localparam int MASK = 32'h3ffff;

	typedef struct {
		bit              first_bit;
		bit [FOL_W-1:0]  follow_count;
		bit              follow_overflow;
		bit              last;
	} coded_bit_t;

	coded_bit_t      coded_q[$];
	int unsigned     rank_of_sym[SYMBOL_COUNT];
	int unsigned     sym_at_rank[RANKS];
	int unsigned     freq_at[RANKS];
	int unsigned     cum_at[RANKS];
	int unsigned     dist_cum[WINDOW_SIZE+1];
	int unsigned     low_b, high_b, pending;
	bit              saturated;
	int              step_count;

	task automatic reset_model();
		cum_at[SYMBOL_COUNT] = 0;
		freq_at[0] = 0;
		sym_at_rank[0] = 0;
		for (int i = SYMBOL_COUNT; i >= 1; i--) begin
			rank_of_sym[i-1] = i;
			sym_at_rank[i] = i - 1;
			freq_at[i] = 1;
			cum_at[i-1] = cum_at[i] + 1;
		end
		dist_cum[WINDOW_SIZE] = 0;
		for (int k = WINDOW_SIZE; k >= 1; k--)
			dist_cum[k-1] = dist_cum[k] + POS_NUM / (k + POS_OFF);
		low_b = 0;
		high_b = FULL;
		pending = 0;
		saturated = 0;
	endtask

	task automatic push_bit(bit b, int unsigned run, bit ovf);
		coded_bit_t e;
		if (step_count >= 40)
			return;
		e.first_bit = b;
		e.follow_count = run[FOL_W-1:0];
		e.follow_overflow = ovf;
		e.last = 0;
		coded_q.push_back(e);
		step_count++;
	endtask

	task automatic bump_pending();
		if (pending >= 32'hffff) begin
			pending = 32'hffff;
			saturated = 1;
		end else begin
			pending++;
		end
	endtask

	task automatic send_run(bit b);
		push_bit(b, pending, saturated);
		pending = 0;
		saturated = 0;
	endtask

	task automatic narrow(int unsigned c_prev, int unsigned c_this, int unsigned total);
		longint unsigned base, span;
		int unsigned lo, hi;
		if (total == 0)
			return;
		base = low_b;
		span = (high_b - low_b) & MASK;
		hi = (base + span * c_prev / total) & MASK;
		lo = (base + span * c_this / total) & MASK;
		for (int s = 0; s < RENORM_STEPS; s++) begin
			if (hi <= HALF) begin
				send_run(0);
			end else if (lo >= HALF) begin
				send_run(1);
				lo -= HALF;
				hi -= HALF;
			end else if (lo >= QTR1 && hi <= QTR3) begin
				bump_pending();
				lo -= QTR1;
				hi -= QTR1;
			end else begin
				break;
			end
			lo = (lo * 2) & MASK;
			hi = (hi * 2) & MASK;
		end
		low_b = lo;
		high_b = hi;
	endtask

	task automatic adapt(int unsigned r);
		int unsigned i, a, b, total;
		if (cum_at[0] >= CUM_LIMIT) begin
			total = 0;
			for (int k = SYMBOL_COUNT; k >= 1; k--) begin
				cum_at[k] = total & 16'hffff;
				freq_at[k] = (freq_at[k] + 1) >> 1;
				total += freq_at[k];
			end
			cum_at[0] = total & 16'hffff;
		end
		i = r;
		while (i > 1 && freq_at[i] == freq_at[i-1])
			i--;
		if (i < r) begin
			a = sym_at_rank[i];
			b = sym_at_rank[r];
			sym_at_rank[i] = b;
			sym_at_rank[r] = a;
			if (a < SYMBOL_COUNT) rank_of_sym[a] = r;
			if (b < SYMBOL_COUNT) rank_of_sym[b] = i;
		end
		freq_at[i] = (freq_at[i] + 1) & 16'hffff;
		while (i > 0) begin
			i--;
			cum_at[i] = (cum_at[i] + 1) & 16'hffff;
		end
	endtask

	task automatic code_symbol(int unsigned c);
		int unsigned r;
		if (c >= SYMBOL_COUNT) c = SYMBOL_COUNT - 1;
		r = rank_of_sym[c];
		if (r < 1 || r > SYMBOL_COUNT) r = 1;
		narrow(cum_at[r-1], cum_at[r], cum_at[0]);
		adapt(r);
	endtask

	task automatic predict(logic [1:0] m, logic [7:0] lit, logic [5:0] len,
			logic [DIST_W-1:0] distance);
		int unsigned l, d;
		step_count = 0;
		case (m)
			MODE_LIT: begin
				code_symbol(lit);
			end
			MODE_MATCH: begin
				l = len;
				d = distance;
				if (l < 3) l = 3;
				if (l > MAX_MATCH) l = MAX_MATCH;
				if (d < 1) d = 1;
				if (d > WINDOW_SIZE) d = WINDOW_SIZE;
				code_symbol(MATCH_BASE + l);
				narrow(dist_cum[d-1], dist_cum[d], dist_cum[0]);
			end
			MODE_FINISH: begin
				bump_pending();
				send_run(low_b < QTR1 ? 1'b0 : 1'b1);
				for (int i = 0; i < FLUSH_ZEROS; i++)
					push_bit(0, 0, 0);
				reset_model();
			end
			default: ;
		endcase
		if (step_count > 0)
			coded_q[$].last = 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		coded_bit_t e;
		int bad;
		bad = 0;
		if (!arst_n) begin
			coded_q.delete();
			reset_model();
			fails <= 0;
			checked <= 0;
		end else begin
			if (tok.valid && tok.ready)
				predict(tok.mode, tok.literal_byte, tok.match_length, tok.match_distance);
			if (res.valid && res.ready) begin
				checked <= checked + 1;
				if (coded_q.size() == 0) begin
					$error("unexpected result: first_bit %0d follow_count %0d",
						res.first_bit, res.follow_count);
					bad++;
				end else begin
					e = coded_q.pop_front();
					if (res.first_bit !== e.first_bit) begin
						$error("first_bit: expected %0d, got %0d", e.first_bit, res.first_bit);
						bad++;
					end
					if (res.follow_count !== e.follow_count) begin
						$error("follow_count: expected %0d, got %0d", e.follow_count,
							res.follow_count);
						bad++;
					end
					if (res.follow_overflow !== e.follow_overflow) begin
						$error("follow_overflow: expected %0d, got %0d", e.follow_overflow,
							res.follow_overflow);
						bad++;
					end
					if (res.last !== e.last) begin
						$error("last: expected %0d, got %0d", e.last, res.last);
						bad++;
					end
				end
			end
			if (bad != 0)
				fails <= fails + bad;
		end
	end

	assign outstanding = coded_q.size();

endmodule

FILE: sim/testbench.sv
// Top of the LZARI token encoder bench: clock, reset, requests, verdict.
// Depends on lzari_pkg, the channel interfaces, the encoder and lzari_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_MATCH   = lzari_pkg::MAX_MATCH;
	localparam int WINDOW_SIZE = lzari_pkg::WINDOW_SIZE;
	localparam int DIST_W      = lzari_pkg::DIST_W;
	localparam logic [1:0] MODE_LIT    = lzari_pkg::MODE_LIT;
	localparam logic [1:0] MODE_MATCH  = lzari_pkg::MODE_MATCH;
	localparam logic [1:0] MODE_FINISH = lzari_pkg::MODE_FINISH;
	localparam logic [1:0] MODE_UNUSED = lzari_pkg::MODE_UNUSED;

	localparam int STALL_LIMIT = 30000;

	logic clk = 0;
	logic arst_n = 0;
	int   fails, outstanding, checked;
	int   n_lit, n_match, n_finish, n_ignored;
	int   quiet_cycles;
	bit   calm;
	bit   done;

	lzari_tok_if tok_ch();
	lzari_res_if res_ch();

	lzari_arith_token_encoder_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok_ch),
		.res    (res_ch)
	);

	lzari_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok         (tok_ch),
		.res         (res_ch),
		.fails       (fails),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		tok_ch.valid = 0;
		tok_ch.mode = MODE_LIT;
		tok_ch.literal_byte = 0;
		tok_ch.match_length = 0;
		tok_ch.match_distance = 0;
		res_ch.ready = 0;
	end

	// hold ready low about 28 percent of the time, except in the calm stretch
	always @(negedge clk)
		res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 28);

	always @(posedge clk) begin
		if (!arst_n || done || (tok_ch.valid && tok_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send(logic [1:0] m, logic [7:0] lit, logic [5:0] len,
			logic [DIST_W-1:0] distance);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 28) begin
			tok_ch.valid <= 0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		tok_ch.valid <= 1;
		tok_ch.mode <= m;
		tok_ch.literal_byte <= lit;
		tok_ch.match_length <= len;
		tok_ch.match_distance <= distance;
		do @(posedge clk); while (!tok_ch.ready);
		case (m)
			MODE_LIT:    n_lit++;
			MODE_MATCH:  n_match++;
			MODE_FINISH: n_finish++;
			default:     n_ignored++;
		endcase
	endtask

	task automatic send_random();
		int pick;
		pick = $urandom_range(99);
		if (pick < 52)
			send(MODE_LIT, ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom),
				6'($urandom), 13'($urandom));
		else if (pick < 90)
			send(MODE_MATCH, 8'($urandom),
				($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(MAX_MATCH, 3)),
				($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(WINDOW_SIZE, 1)));
		else if (pick < 94)
			send(MODE_FINISH, 8'($urandom), 6'($urandom), 13'($urandom));
		else
			send(MODE_UNUSED, 8'($urandom), 6'($urandom), 13'($urandom));
	endtask

	initial begin
		int sent;
		calm = 0;
		done = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		send(MODE_LIT, 8'd0, 6'd0, 13'd0);
		send(MODE_LIT, 8'd255, 6'd63, 13'h1fff);
		send(MODE_LIT, 8'd255, 6'd0, 13'd0);
		send(MODE_MATCH, 8'd0, 6'd3, 13'd1);
		send(MODE_MATCH, 8'hff, 6'd60, 13'd4096);
		send(MODE_MATCH, 8'd0, 6'd0, 13'd0);
		send(MODE_MATCH, 8'd0, 6'd2, 13'd4097);
		send(MODE_MATCH, 8'd0, 6'd61, 13'h1fff);
		send(MODE_MATCH, 8'd0, 6'd63, 13'd2048);
		send(MODE_UNUSED, 8'd5, 6'd10, 13'd10);
		send(MODE_LIT, 8'd7, 6'd0, 13'd0);
		send(MODE_LIT, 8'd7, 6'd0, 13'd0);
		send(MODE_LIT, 8'd7, 6'd0, 13'd0);
		send(MODE_FINISH, 8'hff, 6'h3f, 13'h1fff);
		send(MODE_LIT, 8'd128, 6'd0, 13'd0);
		send(MODE_FINISH, 8'd0, 6'd0, 13'd0);
		send(MODE_FINISH, 8'd0, 6'd0, 13'd0);

		sent = 0;
		while (sent < 320) begin
			calm = (sent >= 120 && sent < 170);
			if (sent == 200) begin
				// drain all results before the next request
				@(negedge clk);
				tok_ch.valid <= 0;
				wait (outstanding == 0);
			end
			send_random();
			if (tok_ch.mode != MODE_UNUSED)
				sent++;
		end
		calm = 0;
		@(negedge clk);
		tok_ch.valid <= 0;
		wait (outstanding == 0);
		done = 1;
		repeat (200) @(posedge clk);

		$display("Requests: %0d literals, %0d matches, %0d finishes, %0d ignored mode 3.",
			n_lit, n_match, n_finish, n_ignored);
		$display("Coded bits checked: %0d.", checked);
		if (fails == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/lzari_pkg.sv
rtl/lzari_if.sv
rtl/lzari_ram.sv
rtl/lzari_cell.sv
rtl/lzari_div.sv
rtl/lzari_arith_token_encoder_unit.sv
sim/lzari_checker.sv
sim/testbench.sv
